// ----- rtl/u2lcd_pkg.sv -----
// shared types and lookup functions for the utf-16 to lcd glyph code translator
package u2lcd_pkg;

  localparam int CodeWidth  = 16;
  localparam int GlyphWidth = 8;

  localparam logic [GlyphWidth-1:0] NoGlyph  = 8'hFF;
  localparam logic [7:0]            KanaPage = 8'h30;

  // one lookup outcome: hit flag and glyph
  typedef struct packed {
    logic                  hit;
    logic [GlyphWidth-1:0] glyph;
  } lookup_t;

  // printable ascii 0x20 to 0x7D, with the descender glyphs for g, j, p and q
  function automatic lookup_t ascii_map(input logic [CodeWidth-1:0] c);
    lookup_t r;
    r.hit   = (c >= 16'h0020) && (c <= 16'h007D);
    r.glyph = c[7:0];
    case (c)
      16'h0067: r.glyph = 8'hE7;
      16'h006A: r.glyph = 8'hEA;
      16'h0070: r.glyph = 8'hF0;
      16'h0071: r.glyph = 8'hF1;
      default:  r.glyph = c[7:0];
    endcase
    return r;
  endfunction

  // katakana rows by offset from the row start; b is the low byte in the kana page
  function automatic lookup_t kana_map(input logic [7:0] b);
    lookup_t    r;
    logic [7:0] d;
    r.hit   = 1'b0;
    r.glyph = NoGlyph;
    d       = 8'h00;
    if (b >= 8'hA2 && b <= 8'hAA && !b[0]) begin
      d = b - 8'hA2;
      r = '{1'b1, 8'hB1 + {1'b0, d[7:1]}};
    end else if (b >= 8'hAB && b <= 8'hC1 && b[0]) begin
      d = b - 8'hAB;
      r = '{1'b1, 8'hB6 + {1'b0, d[7:1]}};
    end else if (b >= 8'hC4 && b <= 8'hC8 && !b[0]) begin
      d = b - 8'hC4;
      r = '{1'b1, 8'hC2 + {1'b0, d[7:1]}};
    end else if (b >= 8'hCA && b <= 8'hCE) begin
      r = '{1'b1, 8'hC5 + (b - 8'hCA)};
    end else if (b >= 8'hDE && b <= 8'hE2) begin
      r = '{1'b1, 8'hCF + (b - 8'hDE)};
    end else if (b >= 8'hE4 && b <= 8'hE8 && !b[0]) begin
      d = b - 8'hE4;
      r = '{1'b1, 8'hD4 + {1'b0, d[7:1]}};
    end else if (b >= 8'hE9 && b <= 8'hED) begin
      r = '{1'b1, 8'hD7 + (b - 8'hE9)};
    end else begin
      // row ha: every third code unit is the plain form
      case (b)
        8'hCF:   r = '{1'b1, 8'hCA};
        8'hD2:   r = '{1'b1, 8'hCB};
        8'hD5:   r = '{1'b1, 8'hCC};
        8'hD8:   r = '{1'b1, 8'hCD};
        8'hDB:   r = '{1'b1, 8'hCE};
        default: r = '{1'b0, NoGlyph};
      endcase
    end
    return r;
  endfunction

  // fixed symbol list: punctuation, small kana, greek, accented latin, kanji
  function automatic lookup_t sym_map(input logic [CodeWidth-1:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      16'h2192: r.glyph = 8'h7E;
      16'h2190: r.glyph = 8'h7F;
      16'h3000: r.glyph = 8'hA0;
      16'h3002: r.glyph = 8'hA1;
      16'h300C: r.glyph = 8'hA2;
      16'h300D: r.glyph = 8'hA3;
      16'h3001: r.glyph = 8'hA4;
      16'h30FB: r.glyph = 8'hA5;
      16'h2219: r.glyph = 8'hA5;
      16'h22C5: r.glyph = 8'hA5;
      16'h30F2: r.glyph = 8'hA6;
      16'h30A1: r.glyph = 8'hA7;
      16'h30A3: r.glyph = 8'hA8;
      16'h30A5: r.glyph = 8'hA9;
      16'h30A7: r.glyph = 8'hAA;
      16'h30A9: r.glyph = 8'hAB;
      16'h30E3: r.glyph = 8'hAC;
      16'h30E5: r.glyph = 8'hAD;
      16'h30E7: r.glyph = 8'hAE;
      16'h30C3: r.glyph = 8'hAF;
      16'h30FC: r.glyph = 8'hB0;
      16'h30EF: r.glyph = 8'hDC;
      16'h30F3: r.glyph = 8'hDD;
      16'h309B: r.glyph = 8'hDE;
      16'h309C: r.glyph = 8'hDF;
      16'h00B0: r.glyph = 8'hDF;
      16'h03B1: r.glyph = 8'hE0;
      16'h00C4: r.glyph = 8'hE1;
      16'h00E4: r.glyph = 8'hE1;
      16'h03B2: r.glyph = 8'hE2;
      16'h00DF: r.glyph = 8'hE2;
      16'h03B5: r.glyph = 8'hE3;
      16'h03BC: r.glyph = 8'hE4;
      16'h03C3: r.glyph = 8'hE5;
      16'h03C1: r.glyph = 8'hE6;
      16'h221A: r.glyph = 8'hE8;
      16'h207B: r.glyph = 8'hE9;
      16'h02E3: r.glyph = 8'hEB;
      16'h00A2: r.glyph = 8'hEC;
      16'h20B5: r.glyph = 8'hEC;
      16'h00A3: r.glyph = 8'hED;
      16'h00D1: r.glyph = 8'hEE;
      16'h00F1: r.glyph = 8'hEE;
      16'h00D6: r.glyph = 8'hEF;
      16'h00F6: r.glyph = 8'hEF;
      16'h03B8: r.glyph = 8'hF2;
      16'h221E: r.glyph = 8'hF3;
      16'h03A9: r.glyph = 8'hF4;
      16'h00DC: r.glyph = 8'hF5;
      16'h00FC: r.glyph = 8'hF5;
      16'h03A3: r.glyph = 8'hF6;
      16'h03C0: r.glyph = 8'hF7;
      16'h5343: r.glyph = 8'hFA;
      16'h4E07: r.glyph = 8'hFB;
      16'h5186: r.glyph = 8'hFC;
      16'h00F7: r.glyph = 8'hFD;
      16'h220E: r.glyph = 8'hFF;
      default: begin
        r.hit   = 1'b0;
        r.glyph = NoGlyph;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/utf16_to_lcd_char_code_unit.sv -----
// utf-16 code unit to a00 character lcd glyph code translator
//
// One utf-16 code unit comes in on the slave stream (s_tdata) and one
// 8-bit glyph code of the a00 character rom leaves on the master stream
// (m_tdata). Unmapped code units give 0xFF.
//
// Throughput: one transaction per cycle while m_tready is not held low;
// the three register stages (capture with ascii decode, kana and symbol
// lookup, final select) each carry a valid bit and advance on their own.
//
// A stall on m_tready holds the output register; earlier stages keep
// filling until every stage holds an item, and only then does s_tready
// drop. Nothing is lost or repeated.
//
// Reset (rst, synchronous) empties all stages; the block holds no other
// state, so the first transaction after reset is translated normally.
module utf16_to_lcd_char_code_unit
  import u2lcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CodeWidth-1:0]  s_tdata,   // [15:0] code_unit
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [GlyphWidth-1:0] m_tdata    // [7:0] glyph_code
);

  // stage valid bits and per-stage ready
  logic va, vb, vc;
  logic rdy_a, rdy_b, rdy_c;

  // stage a: captured code and ascii decode
  logic [CodeWidth-1:0] code_a;
  lookup_t              asc_a;

  // stage b: the three lookup results
  lookup_t asc_b, kana_b, sym_b;

  // stage c: selected glyph
  logic [GlyphWidth-1:0] glyph_c;

  // a stage may load when it is empty or its content moves on
  assign rdy_c    = !vc || m_tready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign s_tready = rdy_a;

  // stage a: capture and ascii decode
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= s_tvalid;
    end
    if (rdy_a && s_tvalid) begin
      code_a <= s_tdata;
      asc_a  <= ascii_map(s_tdata);
    end
  end

  // stage b: kana offsets and symbol list in parallel
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
    if (rdy_b && va) begin
      asc_b <= asc_a;
      sym_b <= sym_map(code_a);
      if (code_a[15:8] == KanaPage) begin
        kana_b <= kana_map(code_a[7:0]);
      end else begin
        kana_b <= '{1'b0, NoGlyph};
      end
    end
  end

  // stage c: priority select ascii, kana, symbol, then no glyph
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= vb;
    end
    if (rdy_c && vb) begin
      if (asc_b.hit) begin
        glyph_c <= asc_b.glyph;
      end else if (kana_b.hit) begin
        glyph_c <= kana_b.glyph;
      end else if (sym_b.hit) begin
        glyph_c <= sym_b.glyph;
      end else begin
        glyph_c <= NoGlyph;
      end
    end
  end

  assign m_tvalid = vc;
  assign m_tdata  = glyph_c;

  // input side never blocks while the output register is empty
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("s_tready low with empty output stage");

  // an ascii hit in stage b always wins the final select
  a_ascii_priority: assert property (@(posedge clk) disable iff (rst)
    (vb && rdy_c && asc_b.hit) |=> (vc && glyph_c == $past(asc_b.glyph)))
    else $error("ascii glyph lost in final select");

  // pipeline is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (!va && !vb && !vc))
    else $error("stage valid set after reset");

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the utf-16 to lcd glyph code translator
`timescale 1ns / 100ps

import u2lcd_pkg::*;

// tracks glyph codes owed by the block, in order of accepted code units
class glyph_scoreboard;
  logic [GlyphWidth-1:0] owed_glyphs[$];
  int unsigned units_taken;
  int unsigned glyphs_checked;
  int unsigned mismatches;

  function new();
    units_taken    = 0;
    glyphs_checked = 0;
    mismatches     = 0;
  endfunction

  // a00 rom code for one utf-16 code unit
  static function logic [GlyphWidth-1:0] glyph_for_unit(input logic [CodeWidth-1:0] c);
    logic [CodeWidth-1:0]  d;
    logic [GlyphWidth-1:0] g;
    d = '0;
    g = NoGlyph;
    if (c == 16'h0067) begin
      g = 8'hE7;
    end else if (c == 16'h006A) begin
      g = 8'hEA;
    end else if (c == 16'h0070) begin
      g = 8'hF0;
    end else if (c == 16'h0071) begin
      g = 8'hF1;
    end else if (c >= 16'h0020 && c <= 16'h007D) begin
      g = c[7:0];
    end else if (c >= 16'h30A2 && c <= 16'h30AA && !c[0]) begin
      // row a: even units are the plain vowels
      d = (c - 16'h30A2) >> 1;
      g = 8'hB1 + d[7:0];
    end else if (c >= 16'h30AB && c <= 16'h30C1 && c[0]) begin
      // rows ka through ta: odd units are unvoiced
      d = (c - 16'h30AB) >> 1;
      g = 8'hB6 + d[7:0];
    end else if (c >= 16'h30C4 && c <= 16'h30C8 && !c[0]) begin
      d = (c - 16'h30C4) >> 1;
      g = 8'hC2 + d[7:0];
    end else if (c >= 16'h30CA && c <= 16'h30CE) begin
      d = c - 16'h30CA;
      g = 8'hC5 + d[7:0];
    end else if (c >= 16'h30CF && c <= 16'h30DB && (c % 3) == 0) begin
      // row ha: plain, voiced and semi-voiced forms rotate by three
      d = 16'((c - 16'h30CF) / 3);
      g = 8'hCA + d[7:0];
    end else if (c >= 16'h30DE && c <= 16'h30E2) begin
      d = c - 16'h30DE;
      g = 8'hCF + d[7:0];
    end else if (c >= 16'h30E4 && c <= 16'h30E8 && !c[0]) begin
      d = (c - 16'h30E4) >> 1;
      g = 8'hD4 + d[7:0];
    end else if (c >= 16'h30E9 && c <= 16'h30ED) begin
      d = c - 16'h30E9;
      g = 8'hD7 + d[7:0];
    end else begin
      // individually mapped symbols, small kana, greek, latin, kanji
      case (c)
        16'h2192: g = 8'h7E;
        16'h2190: g = 8'h7F;
        16'h3000: g = 8'hA0;
        16'h3002: g = 8'hA1;
        16'h300C: g = 8'hA2;
        16'h300D: g = 8'hA3;
        16'h3001: g = 8'hA4;
        16'h30FB, 16'h2219, 16'h22C5: g = 8'hA5;
        16'h30F2: g = 8'hA6;
        16'h30A1: g = 8'hA7;
        16'h30A3: g = 8'hA8;
        16'h30A5: g = 8'hA9;
        16'h30A7: g = 8'hAA;
        16'h30A9: g = 8'hAB;
        16'h30E3: g = 8'hAC;
        16'h30E5: g = 8'hAD;
        16'h30E7: g = 8'hAE;
        16'h30C3: g = 8'hAF;
        16'h30FC: g = 8'hB0;
        16'h30EF: g = 8'hDC;
        16'h30F3: g = 8'hDD;
        16'h309B: g = 8'hDE;
        16'h309C, 16'h00B0: g = 8'hDF;
        16'h03B1: g = 8'hE0;
        16'h00C4, 16'h00E4: g = 8'hE1;
        16'h03B2, 16'h00DF: g = 8'hE2;
        16'h03B5: g = 8'hE3;
        16'h03BC: g = 8'hE4;
        16'h03C3: g = 8'hE5;
        16'h03C1: g = 8'hE6;
        16'h221A: g = 8'hE8;
        16'h207B: g = 8'hE9;
        16'h02E3: g = 8'hEB;
        16'h00A2, 16'h20B5: g = 8'hEC;
        16'h00A3: g = 8'hED;
        16'h00D1, 16'h00F1: g = 8'hEE;
        16'h00D6, 16'h00F6: g = 8'hEF;
        16'h03B8: g = 8'hF2;
        16'h221E: g = 8'hF3;
        16'h03A9: g = 8'hF4;
        16'h00DC, 16'h00FC: g = 8'hF5;
        16'h03A3: g = 8'hF6;
        16'h03C0: g = 8'hF7;
        16'h5343: g = 8'hFA;
        16'h4E07: g = 8'hFB;
        16'h5186: g = 8'hFC;
        16'h00F7: g = 8'hFD;
        default:  g = NoGlyph;
      endcase
    end
    return g;
  endfunction

  // accepted input transaction: queue the glyph it must produce
  function void note_code_unit(input logic [CodeWidth-1:0] c);
    owed_glyphs.push_back(glyph_for_unit(c));
    units_taken++;
  endfunction

  // accepted output transaction: compare with the oldest owed glyph
  function void check_glyph(input logic [GlyphWidth-1:0] g);
    logic [GlyphWidth-1:0] want;
    if (owed_glyphs.size() == 0) begin
      $error("glyph_code: unexpected transaction, expected none, actual 0x%02h", g);
      mismatches++;
    end else begin
      want = owed_glyphs.pop_front();
      glyphs_checked++;
      if (g !== want) begin
        $error("glyph_code: expected 0x%02h, actual 0x%02h", want, g);
        mismatches++;
      end
    end
  endfunction

  function int unsigned owed_count();
    return owed_glyphs.size();
  endfunction
endclass

module testbench;

  localparam int RandomUnits = 1700;
  localparam int CalmTail    = 200;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [CodeWidth-1:0]  s_tdata;    // [15:0] code_unit
  logic                  m_tvalid;
  logic                  m_tready;
  logic [GlyphWidth-1:0] m_tdata;    // [7:0] glyph_code

  glyph_scoreboard glyph_sb;
  int unsigned     gap_pct;
  int unsigned     cycle_count;
  int unsigned     ready_hold;

  // code units that hit the symbol list, plus the ascii descenders, picked often by the random part
  logic [CodeWidth-1:0] symbol_units [61] = '{
    16'h2192, 16'h2190, 16'h3000, 16'h3002, 16'h300C, 16'h300D, 16'h3001, 16'h30FB,
    16'h2219, 16'h22C5, 16'h30F2, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9,
    16'h30E3, 16'h30E5, 16'h30E7, 16'h30C3, 16'h30FC, 16'h30EF, 16'h30F3, 16'h309B,
    16'h309C, 16'h00B0, 16'h03B1, 16'h00C4, 16'h00E4, 16'h03B2, 16'h00DF, 16'h03B5,
    16'h03BC, 16'h03C3, 16'h03C1, 16'h221A, 16'h207B, 16'h02E3, 16'h00A2, 16'h20B5,
    16'h00A3, 16'h00D1, 16'h00F1, 16'h00D6, 16'h00F6, 16'h03B8, 16'h221E, 16'h03A9,
    16'h00DC, 16'h00FC, 16'h03A3, 16'h03C0, 16'h5343, 16'h4E07, 16'h5186, 16'h00F7,
    16'h220E, 16'h0067, 16'h006A, 16'h0070, 16'h0071
  };

  // boundaries, descenders, yen sign, arrows, kana row edges, surrogates
  logic [CodeWidth-1:0] edge_units [25] = '{
    16'h0000, 16'hFFFF, 16'h001F, 16'h0020, 16'h005C, 16'h0067, 16'h006A, 16'h0070,
    16'h0071, 16'h007D, 16'h007E, 16'h007F, 16'h30A2, 16'h30A3, 16'h30AB, 16'h30C1,
    16'h30C4, 16'h30CA, 16'h30CF, 16'h30D0, 16'h30DB, 16'h30E9, 16'h5186, 16'h220E,
    16'hD800
  };

  utf16_to_lcd_char_code_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // transaction monitor on both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) glyph_sb.note_code_unit(s_tdata);
      if (m_tvalid && m_tready) glyph_sb.check_glyph(m_tdata);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver backpressure in bursts
  always @(negedge clk) begin
    if (ready_hold > 0 && gap_pct > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      m_tready   <= 1'b0;
      ready_hold = $urandom_range(1, 18) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // present one code unit, called at a falling edge, returns at a falling edge
  task automatic send_code_unit(input logic [CodeWidth-1:0] c);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender gap in bursts before the next transaction
  task automatic maybe_idle_source();
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // random code unit weighted toward the mapped regions
  function automatic logic [CodeWidth-1:0] pick_code_unit();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return 16'(16'h3090 + $urandom_range(0, 111));
    if (sel < 50) return 16'($urandom_range(0, 127));
    if (sel < 65) return symbol_units[$urandom_range(0, 60)];
    if (sel < 75) return 16'($urandom_range(16'h0080, 16'h00FF));
    if (sel < 80) return 16'($urandom_range(16'hD800, 16'hDFFF));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // stimulus and end of test
  initial begin
    glyph_sb    = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    gap_pct     = 0;
    cycle_count = 0;
    ready_hold  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corner cases, light idling
    gap_pct = 15;
    foreach (edge_units[i]) begin
      maybe_idle_source();
      send_code_unit(edge_units[i]);
    end

    // random traffic; idling density redrawn every 150 transactions, none in the calm tail
    for (int n = 0; n < RandomUnits; n++) begin
      if (n >= RandomUnits - CalmTail) begin
        gap_pct = 0;
      end else if (n % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 5;
          2: gap_pct = 20;
          default: gap_pct = 40;
        endcase
      end
      maybe_idle_source();
      send_code_unit(pick_code_unit());
    end
    s_tvalid <= 1'b0;
    gap_pct  = 0;

    // drain, then give a stray result time to show up
    while (glyph_sb.owed_count() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (glyph_sb.owed_count() != 0) begin
      $error("glyph_code: %0d transactions never produced a result",
             glyph_sb.owed_count());
      glyph_sb.mismatches++;
    end

    $display("translated %0d code units (corner cases, kana rows, symbols, surrogates)",
             glyph_sb.units_taken);
    $display("checked %0d glyph codes under bursty backpressure, %0d mismatches",
             glyph_sb.glyphs_checked, glyph_sb.mismatches);
    if (glyph_sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
